// ----- design/gisu_pkg.sv -----
// Package for the gap interval set update block: types, codes and control interfaces.
`timescale 1ns / 1ps
`default_nettype none

package gisu_pkg;

   typedef enum logic [2:0] {
      KIND_UNDO_DELETE  = 3'd0,
      KIND_UNDO_RESTORE = 3'd1,
      KIND_REP_SET      = 3'd2,
      KIND_REP_REMOVED  = 3'd3,
      KIND_NO_CHANGE    = 3'd4,
      KIND_TABLE_FULL   = 3'd5
   } rec_kind_type;

   localparam logic OP_ADD = 1'b0;

   typedef struct packed {
      logic        req_type;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic        report_changes;
   } req_item_type;

   typedef struct packed {
      rec_kind_type record_kind;
      logic [31:0]  rec_start;
      logic [31:0]  rec_end;
      logic         last;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] first;
      logic [31:0] last;
   } entry_type;

   typedef enum logic [4:0] {
      STEP_NONE,
      STEP_START,
      STEP_READ,
      STEP_A_HOLD,
      STEP_A_EXTEND,
      STEP_A_INSERT,
      STEP_M_ABSORB,
      STEP_M_MERGE,
      STEP_M_CLOSE,
      STEP_COPY,
      STEP_R_COVER,
      STEP_R_LEFT,
      STEP_R_RIGHT,
      STEP_R_MID,
      STEP_R_MID2,
      STEP_FIN_COMMIT,
      STEP_FIN_NOCHG,
      STEP_FIN_FULL
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_ADD,
      ST_EV_ADD,
      ST_RD_MRG,
      ST_EV_MRG,
      ST_RD_CPY,
      ST_EV_CPY,
      ST_RD_REM,
      ST_EV_REM,
      ST_MID2,
      ST_FIN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic rng_bad;
      logic is_add;
      logic at_end;
      logic full_n;
      logic pend_ok;
      logic pend_empty;
      logic hold_v;
      logic s_le_hip1;
      logic e_le_hip;
      logic ent_lo_le_s;
      logic ent_lo_lt_s;
      logic ent_hi_lt_s;
      logic ent_lo_gt_e;
      logic ent_hi_le_e;
      logic ent_lo_le_ep1;
   } status_type;

endpackage

`default_nettype wire

// ----- design/gap_interval_set_update.sv -----
// Top level of the gap interval set update block: sequencer plus datapath.
// A request runs from accept to the next accept through the check, a table read and
// an evaluate/write step for each range walked, the insert or extend step and closing
// write of an add, the commit, and the drain of the record queue; result-side stalls
// lengthen it. One request is in work at a time. Reset empties the table (count
// zero); table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module gap_interval_set_update import gisu_pkg::*; #(
   parameter int MAX_RANGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_data
);

   cmd_type    cmd;
   status_type stat;

   gisu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gisu_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a transaction while one is in work");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_A_EXTEND || cmd.step == STEP_A_INSERT ||
       cmd.step == STEP_M_ABSORB || cmd.step == STEP_M_MERGE ||
       cmd.step == STEP_R_COVER || cmd.step == STEP_R_LEFT ||
       cmd.step == STEP_R_RIGHT || cmd.step == STEP_R_MID) |-> stat.pend_ok)
      else $error("record queue overflow");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.step == STEP_FIN_FULL |-> stat.full_n)
      else $error("table full reported with room left");
`endif

endmodule

`default_nettype wire

// ----- design/gisu_ctrl.sv -----
// Sequencer for the gap interval set update: walks the table and picks one step a cycle.
`timescale 1ns / 1ps
`default_nettype none

module gisu_ctrl import gisu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type stat,
   output cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic ent_v;
      ent_v     = (state_ff == ST_EV_ADD);
      state_in  = state_ff;
      cmd.step  = STEP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = STEP_START;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.rng_bad) begin
               cmd.step = STEP_FIN_NOCHG;
               state_in = ST_DONE;
            end else if (stat.is_add) begin
               state_in = ST_RD_ADD;
            end else begin
               state_in = ST_RD_REM;
            end
         end
         ST_RD_ADD, ST_EV_ADD: begin
            if (state_ff == ST_RD_ADD && !stat.at_end) begin
               cmd.step = STEP_READ;
               state_in = ST_EV_ADD;
            end else if (ent_v && stat.ent_lo_le_s) begin
               cmd.step = STEP_A_HOLD;
               state_in = ST_RD_ADD;
            end else if (stat.hold_v && stat.s_le_hip1) begin
               // new range overlaps or touches the entry before it
               if (stat.e_le_hip) begin
                  cmd.step = STEP_FIN_NOCHG;
                  state_in = ST_DONE;
               end else if (stat.pend_ok) begin
                  cmd.step = STEP_A_EXTEND;
                  state_in = ent_v ? ST_EV_MRG : ST_RD_MRG;
               end
            end else if (stat.full_n && !(ent_v && stat.ent_lo_le_ep1)) begin
               cmd.step = STEP_FIN_FULL;
               state_in = ST_DONE;
            end else if (stat.pend_ok) begin
               cmd.step = STEP_A_INSERT;
               state_in = ent_v ? ST_EV_MRG : ST_RD_MRG;
            end
         end
         ST_RD_MRG: begin
            if (stat.at_end) begin
               cmd.step = STEP_M_CLOSE;
               state_in = ST_FIN;
            end else begin
               cmd.step = STEP_READ;
               state_in = ST_EV_MRG;
            end
         end
         ST_EV_MRG: begin
            if (stat.pend_ok) begin
               priority if (stat.ent_hi_le_e) begin
                  cmd.step = STEP_M_ABSORB;
                  state_in = ST_RD_MRG;
               end else if (stat.ent_lo_le_ep1) begin
                  cmd.step = STEP_M_MERGE;
                  state_in = ST_RD_CPY;
               end else begin
                  cmd.step = STEP_M_CLOSE;
                  state_in = ST_EV_CPY;
               end
            end
         end
         ST_RD_CPY: begin
            if (stat.at_end) begin
               state_in = ST_FIN;
            end else begin
               cmd.step = STEP_READ;
               state_in = ST_EV_CPY;
            end
         end
         ST_EV_CPY: begin
            cmd.step = STEP_COPY;
            state_in = ST_RD_CPY;
         end
         ST_RD_REM: begin
            if (stat.at_end) begin
               state_in = ST_FIN;
            end else begin
               cmd.step = STEP_READ;
               state_in = ST_EV_REM;
            end
         end
         ST_EV_REM: begin
            if (stat.ent_hi_lt_s || stat.ent_lo_gt_e) begin
               cmd.step = STEP_COPY;
               state_in = ST_RD_REM;
            end else if (stat.pend_ok) begin
               if (stat.ent_lo_lt_s) begin
                  if (stat.ent_hi_le_e) begin
                     cmd.step = STEP_R_LEFT;
                     state_in = ST_RD_REM;
                  end else if (stat.full_n) begin
                     cmd.step = STEP_FIN_FULL;
                     state_in = ST_DONE;
                  end else begin
                     cmd.step = STEP_R_MID;
                     state_in = ST_MID2;
                  end
               end else begin
                  cmd.step = stat.ent_hi_le_e ? STEP_R_COVER : STEP_R_RIGHT;
                  state_in = ST_RD_REM;
               end
            end
         end
         ST_MID2: begin
            cmd.step = STEP_R_MID2;
            state_in = ST_RD_REM;
         end
         ST_FIN: begin
            cmd.step = STEP_FIN_COMMIT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.pend_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/gisu_dp.sv -----
// Datapath for the gap interval set update: banked range table, record queue, result register.
`timescale 1ns / 1ps
`default_nettype none

module gisu_dp import gisu_pkg::*; #(
   parameter int MAX_RANGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output status_type        stat,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_data
);

   localparam int IW    = $clog2(MAX_RANGES);
   localparam int CW    = $clog2(MAX_RANGES + 1);
   localparam int AW    = IW + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int PD    = 5;

   function automatic rsp_item_type mk(rec_kind_type k, logic [31:0] a, logic [31:0] b);
      rsp_item_type r;
      r.record_kind = k;
      r.rec_start   = a;
      r.rec_end     = b;
      r.last        = 1'b0;
      return r;
   endfunction

   // two banks: read from bank_ff, rebuilt table goes to the other one
   entry_type table_mem [DEPTH];

   logic          op_ff;
   logic [31:0]   s_ff, e_ff;
   logic          rep_ff;
   logic          bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   entry_type     hold_ff;
   logic          hold_v_ff, hold_v_in;
   logic [31:0]   cur_lo_ff;
   entry_type     rdata_ff;
   logic          any_rec_ff, any_rec_in;
   logic          done_ff, done_in;
   rsp_item_type  pend_ff [PD];
   rsp_item_type  pend_in [PD];
   logic [2:0]    pend_cnt_ff, pend_cnt_in;
   rsp_item_type  out_ff;
   logic          out_v_ff, out_v_in;

   rsp_item_type  nrec [4];
   logic [2:0]    push_n;
   logic          wr_en;
   entry_type     wr_data;
   logic          rd_inc;
   logic          pop;
   logic [2:0]    base;
   entry_type     ent;

   assign ent = rdata_ff;

   always_comb begin
      push_n  = '0;
      wr_en   = 1'b0;
      wr_data = '0;
      rd_inc  = 1'b0;
      for (int k = 0; k < 4; k++) begin
         nrec[k] = '0;
      end
      unique case (cmd.step)
         STEP_A_HOLD: begin
            wr_en   = hold_v_ff;
            wr_data = hold_ff;
            rd_inc  = 1'b1;
         end
         STEP_A_EXTEND: begin
            nrec[0] = mk(KIND_UNDO_RESTORE, hold_ff.first, hold_ff.last);
            nrec[1] = mk(KIND_REP_SET, hold_ff.first, e_ff);
            push_n  = rep_ff ? 3'd2 : 3'd1;
         end
         STEP_A_INSERT: begin
            wr_en   = hold_v_ff;
            wr_data = hold_ff;
            nrec[0] = mk(KIND_UNDO_DELETE, s_ff, e_ff);
            nrec[1] = mk(KIND_REP_SET, s_ff, e_ff);
            push_n  = rep_ff ? 3'd2 : 3'd1;
         end
         STEP_M_ABSORB, STEP_R_COVER: begin
            rd_inc  = 1'b1;
            nrec[0] = mk(KIND_UNDO_RESTORE, ent.first, ent.last);
            nrec[1] = mk(KIND_REP_REMOVED, ent.first, ent.last);
            push_n  = rep_ff ? 3'd2 : 3'd1;
         end
         STEP_M_MERGE: begin
            rd_inc        = 1'b1;
            wr_en         = 1'b1;
            wr_data.first = cur_lo_ff;
            wr_data.last  = ent.last;
            nrec[0] = mk(KIND_UNDO_RESTORE, cur_lo_ff, e_ff);
            nrec[1] = mk(KIND_UNDO_RESTORE, ent.first, ent.last);
            nrec[2] = mk(KIND_REP_SET, cur_lo_ff, ent.last);
            nrec[3] = mk(KIND_REP_REMOVED, ent.first, ent.last);
            push_n  = rep_ff ? 3'd4 : 3'd2;
         end
         STEP_M_CLOSE: begin
            wr_en         = 1'b1;
            wr_data.first = cur_lo_ff;
            wr_data.last  = e_ff;
         end
         STEP_COPY: begin
            rd_inc  = 1'b1;
            wr_en   = 1'b1;
            wr_data = ent;
         end
         STEP_R_LEFT: begin
            rd_inc        = 1'b1;
            wr_en         = 1'b1;
            wr_data.first = ent.first;
            wr_data.last  = s_ff - 32'd1;
            nrec[0] = mk(KIND_UNDO_RESTORE, ent.first, ent.last);
            nrec[1] = mk(KIND_REP_SET, ent.first, s_ff - 32'd1);
            push_n  = rep_ff ? 3'd2 : 3'd1;
         end
         STEP_R_RIGHT: begin
            rd_inc        = 1'b1;
            wr_en         = 1'b1;
            wr_data.first = e_ff + 32'd1;
            wr_data.last  = ent.last;
            nrec[0] = mk(KIND_UNDO_DELETE, e_ff + 32'd1, ent.last);
            nrec[1] = mk(KIND_UNDO_RESTORE, ent.first, ent.last);
            nrec[2] = mk(KIND_REP_SET, e_ff + 32'd1, ent.last);
            nrec[3] = mk(KIND_REP_REMOVED, ent.first, ent.last);
            push_n  = rep_ff ? 3'd4 : 3'd2;
         end
         STEP_R_MID: begin
            wr_en         = 1'b1;
            wr_data.first = ent.first;
            wr_data.last  = s_ff - 32'd1;
            nrec[0] = mk(KIND_UNDO_DELETE, e_ff + 32'd1, ent.last);
            nrec[1] = mk(KIND_UNDO_RESTORE, ent.first, ent.last);
            nrec[2] = mk(KIND_REP_SET, e_ff + 32'd1, ent.last);
            nrec[3] = mk(KIND_REP_SET, ent.first, s_ff - 32'd1);
            push_n  = rep_ff ? 3'd4 : 3'd2;
         end
         STEP_R_MID2: begin
            rd_inc        = 1'b1;
            wr_en         = 1'b1;
            wr_data.first = e_ff + 32'd1;
            wr_data.last  = ent.last;
         end
         STEP_FIN_COMMIT: begin
            nrec[0] = mk(KIND_NO_CHANGE, s_ff, e_ff);
            push_n  = any_rec_ff ? 3'd0 : 3'd1;
         end
         STEP_FIN_NOCHG: begin
            nrec[0] = mk(KIND_NO_CHANGE, s_ff, e_ff);
            push_n  = 3'd1;
         end
         STEP_FIN_FULL: begin
            nrec[0] = mk(KIND_TABLE_FULL, s_ff, e_ff);
            push_n  = 3'd1;
         end
         default: begin
         end
      endcase
   end

   // record queue: the newest record is held back until a successor or the end is known
   always_comb begin
      pop = (pend_cnt_ff != 3'd0) && (!out_v_ff || rsp_ready) &&
            ((pend_cnt_ff >= 3'd2) || done_ff);
      base = pend_cnt_ff - {2'b00, pop};
      for (int j = 0; j < PD - 1; j++) begin
         pend_in[j] = pop ? pend_ff[j + 1] : pend_ff[j];
      end
      pend_in[PD - 1] = pend_ff[PD - 1];
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < push_n) begin
            pend_in[base + 3'(k)] = nrec[k];
         end
      end
      pend_cnt_in = base + push_n;
      out_v_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);
   end

   always_comb begin
      bank_in    = bank_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff + {{(CW - 1){1'b0}}, rd_inc};
      wr_idx_in  = wr_idx_ff + {{(CW - 1){1'b0}}, wr_en};
      hold_v_in  = hold_v_ff;
      any_rec_in = any_rec_ff | (push_n != 3'd0);
      done_in    = done_ff;
      unique case (cmd.step)
         STEP_START: begin
            rd_idx_in  = '0;
            wr_idx_in  = '0;
            hold_v_in  = 1'b0;
            any_rec_in = 1'b0;
            done_in    = 1'b0;
         end
         STEP_A_HOLD: begin
            hold_v_in = 1'b1;
         end
         STEP_FIN_COMMIT: begin
            bank_in  = ~bank_ff;
            count_in = wr_idx_ff;
            done_in  = 1'b1;
         end
         STEP_FIN_NOCHG, STEP_FIN_FULL: begin
            done_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff     <= 1'b0;
         count_ff    <= '0;
         rd_idx_ff   <= '0;
         wr_idx_ff   <= '0;
         hold_v_ff   <= 1'b0;
         any_rec_ff  <= 1'b0;
         done_ff     <= 1'b0;
         pend_cnt_ff <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         bank_ff     <= bank_in;
         count_ff    <= count_in;
         rd_idx_ff   <= rd_idx_in;
         wr_idx_ff   <= wr_idx_in;
         hold_v_ff   <= hold_v_in;
         any_rec_ff  <= any_rec_in;
         done_ff     <= done_in;
         pend_cnt_ff <= pend_cnt_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step == STEP_START) begin
         op_ff  <= req_data.req_type;
         s_ff   <= req_data.range_start;
         e_ff   <= req_data.range_end;
         rep_ff <= req_data.report_changes;
      end
      if (cmd.step == STEP_A_HOLD) begin
         hold_ff <= ent;
      end
      if (cmd.step == STEP_A_EXTEND) begin
         cur_lo_ff <= hold_ff.first;
      end else if (cmd.step == STEP_A_INSERT) begin
         cur_lo_ff <= s_ff;
      end
      for (int j = 0; j < PD; j++) begin
         pend_ff[j] <= pend_in[j];
      end
      if (pop) begin
         out_ff <= '{record_kind: pend_ff[0].record_kind,
                     rec_start:   pend_ff[0].rec_start,
                     rec_end:     pend_ff[0].rec_end,
                     last:        (pend_cnt_ff == 3'd1) && done_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[{~bank_ff, wr_idx_ff[IW-1:0]}] <= wr_data;
      end
      if (cmd.step == STEP_READ) begin
         rdata_ff <= table_mem[{bank_ff, rd_idx_ff[IW-1:0]}];
      end
   end

   always_comb begin
      stat.rng_bad       = s_ff > e_ff;
      stat.is_add        = (op_ff == OP_ADD);
      stat.at_end        = (rd_idx_ff == count_ff);
      stat.full_n        = (count_ff == CW'(MAX_RANGES));
      stat.pend_ok       = (pend_cnt_ff <= 3'd1);
      stat.pend_empty    = (pend_cnt_ff == 3'd0);
      stat.hold_v        = hold_v_ff;
      stat.s_le_hip1     = {1'b0, s_ff} <= ({1'b0, hold_ff.last} + 33'd1);
      stat.e_le_hip      = e_ff <= hold_ff.last;
      stat.ent_lo_le_s   = ent.first <= s_ff;
      stat.ent_lo_lt_s   = ent.first < s_ff;
      stat.ent_hi_lt_s   = ent.last < s_ff;
      stat.ent_lo_gt_e   = ent.first > e_ff;
      stat.ent_hi_le_e   = ent.last <= e_ff;
      stat.ent_lo_le_ep1 = {1'b0, ent.first} <= ({1'b0, e_ff} + 33'd1);
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
